// File: design/bf2d_pkg.sv
`default_nettype none
package bf2d_pkg;

  localparam int WINDOW          = 5;
  localparam int MAX_WIDTH       = 4096;
  localparam int EXP_TABLE_DEPTH = 1024;

  localparam int HALF       = WINDOW / 2;
  localparam int SPAN       = 2 * HALF + 1;
  localparam int TAPS       = SPAN * SPAN;
  localparam int PIX_W      = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W      = 16;
  localparam int ROW_W      = HGT_W + 1;
  localparam int TAP_W      = $clog2(SPAN);
  localparam int DIST_W     = $clog2(2 * HALF * HALF + 1);
  localparam int EXP_ADDR_W = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_LIMIT  = 28;
  localparam int COEF_W     = 32;
  localparam int ACC_W      = 2 * PIX_W + $clog2(TAPS);
  localparam int G_W        = PIX_W + $clog2(TAPS);
  localparam int NUM_W      = ACC_W + 1;
  localparam int DCNT_W     = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COEFF   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_COEFF = 2'd3;

  typedef logic [PIX_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  typedef struct packed {
    logic              valid;
    logic              inb;
    logic [PIX_W-1:0]  v;
    logic [PIX_W-1:0]  d;
    logic [DIST_W-1:0] dist2;
  } tap_t;

  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned q;
    longint unsigned a;
    longint unsigned e;
    exp_rom_t r;
    term = 64'd1 << 56;
    pos  = term;
    neg  = 0;
    for (int n = 1; n <= 24; n++) begin
      term = div_u64(term * 16, longint'(EXP_TABLE_DEPTH) * n);
      if (n[0]) neg += term;
      else pos += term;
    end
    q = ((pos - neg) + (64'd1 << 23)) >> 24;
    a = 64'd1 << 32;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      e = (a + 64'd32768) >> 16;
      r[k] = (e > 64'd65535) ? 16'hFFFF : e[PIX_W-1:0];
      a = (a * q + (64'd1 << 31)) >> 32;
    end
    return r;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  function automatic logic [DIST_W-1:0] tap_dist2(logic [TAP_W-1:0] j, logic [TAP_W-1:0] i);
    int dx;
    int dy;
    int s;
    dx = int'(j) - HALF;
    dy = int'(i) - HALF;
    s  = dx * dx + dy * dy;
    return s[DIST_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/bf2d_weight.sv
`default_nettype none
module bf2d_weight
  import bf2d_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire tap_t              tap,
  input  wire logic [COEF_W-1:0] range_coeff,
  input  wire logic [COEF_W-1:0] spatial_coeff,
  output logic                   busy,
  output logic [ACC_W-1:0]       wsum_px,
  output logic [G_W-1:0]         wsum
);

  logic [5:0] pv;

  logic              s1_inb;
  logic [PIX_W-1:0]  s1_v;
  logic [2*PIX_W-1:0] s1_dsq;
  logic [DIST_W-1:0] s1_dist2;

  logic              s2_inb;
  logic [PIX_W-1:0]  s2_v;
  logic [63:0]       s2_xr;
  logic [COEF_W+DIST_W-1:0] s2_xs;

  logic              s3_ok;
  logic [PIX_W-1:0]  s3_v;
  logic [EXP_ADDR_W-1:0] s3_idx;

  logic [PIX_W-1:0]  s4_v;
  logic [PIX_W-1:0]  s4_wt;

  logic [PIX_W-1:0]  s5_wt;
  logic [2*PIX_W-1:0] s5_prod;

  logic [64:0] xsum;

  assign xsum = {1'b0, s2_xr} + {{(65-COEF_W-DIST_W){1'b0}}, s2_xs};
  assign busy = tap.valid | (|pv);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[4:0], tap.valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_inb   <= tap.inb;
    s1_v     <= tap.v;
    s1_dsq   <= tap.d * tap.d;
    s1_dist2 <= tap.dist2;

    s2_inb <= s1_inb;
    s2_v   <= s1_v;
    s2_xr  <= 64'(range_coeff) * 64'(s1_dsq);
    s2_xs  <= (COEF_W+DIST_W)'(spatial_coeff) * (COEF_W+DIST_W)'(s1_dist2);

    s3_ok  <= s2_inb && (xsum[64:EXP_LIMIT] == '0);
    s3_v   <= s2_v;
    s3_idx <= xsum[EXP_LIMIT-1 -: EXP_ADDR_W];

    s4_v  <= s3_v;
    s4_wt <= s3_ok ? EXP_ROM[s3_idx] : '0;

    s5_wt   <= s4_wt;
    s5_prod <= s4_wt * s4_v;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      wsum_px <= '0;
      wsum    <= '0;
    end else if (pv[4]) begin
      wsum_px <= wsum_px + ACC_W'(s5_prod);
      wsum    <= wsum + G_W'(s5_wt);
    end
  end

endmodule
`default_nettype wire

// File: design/bf2d_div.sv
`default_nettype none
module bf2d_div
  import bf2d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ACC_W-1:0] num_in,
  input  wire logic [G_W-1:0]   den_in,
  output logic                  done,
  output logic [PIX_W-1:0]      quot
);

  logic [NUM_W-1:0]  qn;
  logic [G_W:0]      rem;
  logic [G_W-1:0]    den;
  logic [DCNT_W-1:0] cnt;
  logic              run;
  logic [G_W:0]      trial;
  logic              ge;

  assign trial = {rem[G_W-1:0], qn[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DCNT_W'(NUM_W);
        den <= den_in;
        rem <= '0;
        qn  <= {1'b0, num_in} + NUM_W'(den_in >> 1);
      end else if (run) begin
        rem <= ge ? trial - {1'b0, den} : trial;
        qn  <= {qn[NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (den == '0) quot = '0;
    else if (qn[NUM_W-1:PIX_W] != '0) quot = '1;
    else quot = qn[PIX_W-1:0];
  end

endmodule
`default_nettype wire

// File: design/bilateral_filter_2d.sv
// Channel   Direction  Signals
// in        sink       in_valid, in_ready, pixel_in, flush
// out       source     out_valid, out_ready, pixel_out, end_of_line, end_of_frame
// cfg       sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A request that makes no result stays in ST_IDLE; one that only moves the line
// memory also passes ST_SHIFT (registered read, then write-back of the shifted
// column). One that makes a result also walks ST_TAPS, ST_DRAIN, ST_DIV and ST_OUT,
// for the single weight pipeline over all window taps and the bit-serial divider.
// The finished result waits in the output register while the next request is taken.
// Reset clears counters and control; the line memory needs no clearing.
`default_nettype none
module bilateral_filter_2d
  import bf2d_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     pixel_in,
  input  wire logic                 flush,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          pixel_out,
  output logic                      end_of_line,
  output logic                      end_of_frame,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SHIFT = 6'b000010,
    ST_TAPS  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  typedef logic [SPAN-2:0][PIX_W-1:0] row_t;

  state_t state;

  logic [WID_W-1:0]  frame_width;
  logic [HGT_W-1:0]  frame_height;
  logic [COEF_W-1:0] range_coeff;
  logic [COEF_W-1:0] spatial_coeff;

  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_column;
  logic [HGT_W-1:0] out_row;

  row_t line_mem [MAX_WIDTH];
  row_t rd_row;
  row_t wr_row;

  logic [PIX_W-1:0] win [SPAN][SPAN];

  logic [COL_W-1:0] cur_col;
  logic [PIX_W-1:0] cur_pix;
  logic             cur_emit;
  logic [COL_W-1:0] tap_oc;
  logic [HGT_W-1:0] tap_or;
  logic             res_eol;
  logic             res_eof;
  logic [TAP_W-1:0] tj;
  logic [TAP_W-1:0] ti;

  logic [WID_W-1:0] w;
  logic [HGT_W-1:0] h;
  logic             in_done;
  logic             accept;
  logic             advance;
  logic [ROW_W+WID_W-1:0] pos;
  logic [ROW_W+WID_W-1:0] lag;
  logic             eol;
  logic             eof;
  logic [COL_W:0]   in_column_inc;
  logic [COL_W:0]   out_column_inc;
  logic [HGT_W:0]   out_row_inc;

  tap_t             tap;
  logic [PIX_W-1:0] center;
  logic [COL_W:0]   cpos;
  logic [HGT_W:0]   rpos;

  logic             w_busy;
  logic [ACC_W-1:0] wsum_px;
  logic [G_W-1:0]   wsum;
  logic             div_start;
  logic             div_done;
  logic [PIX_W-1:0] quot;

  always_comb begin
    if (frame_width == '0) w = WID_W'(1);
    else if (frame_width > WID_W'(MAX_WIDTH)) w = WID_W'(MAX_WIDTH);
    else w = frame_width;
    h = (frame_height == '0) ? HGT_W'(1) : frame_height;
  end

  assign in_done  = in_row >= {1'b0, h};
  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;
  assign advance  = accept && !(flush && !in_done);
  assign cfg_ready = 1'b1;

  assign pos = in_row * w + (ROW_W+WID_W)'(in_column);
  assign lag = (ROW_W+WID_W)'(HALF) * (ROW_W+WID_W)'(w) + (ROW_W+WID_W)'(HALF);

  assign in_column_inc  = {1'b0, in_column} + 1'b1;
  assign out_column_inc = {1'b0, out_column} + 1'b1;
  assign out_row_inc    = {1'b0, out_row} + 1'b1;
  assign eol = out_column_inc >= (COL_W+1)'(w);
  assign eof = eol && (out_row_inc >= {1'b0, h});

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= WID_W'(1024);
      frame_height  <= HGT_W'(1024);
      range_coeff   <= COEF_W'(103563);
      spatial_coeff <= COEF_W'(932068);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[WID_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[HGT_W-1:0];
        REG_RANGE_COEFF:   range_coeff   <= cfg_data;
        REG_SPATIAL_COEFF: spatial_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < SPAN - 2; i++) begin
      wr_row[i] = rd_row[i+1];
    end
    wr_row[SPAN-2] = cur_pix;
  end

  always_ff @(posedge clk) begin
    if (advance) rd_row <= line_mem[in_column];
    if (state == ST_SHIFT) line_mem[cur_col] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (state == ST_SHIFT) begin
      for (int j = 0; j < SPAN - 1; j++) begin
        for (int i = 0; i < SPAN; i++) begin
          win[j][i] <= win[j+1][i];
        end
      end
      for (int i = 0; i < SPAN - 1; i++) begin
        win[SPAN-1][i] <= rd_row[i];
      end
      win[SPAN-1][SPAN-1] <= cur_pix;
    end
  end

  assign center = win[HALF][HALF];
  assign cpos   = {1'b0, tap_oc} + (COL_W+1)'(tj);
  assign rpos   = {1'b0, tap_or} + (HGT_W+1)'(ti);

  always_comb begin
    tap.valid = state == ST_TAPS;
    tap.v     = win[tj][ti];
    tap.d     = (tap.v > center) ? tap.v - center : center - tap.v;
    tap.dist2 = tap_dist2(tj, ti);
    tap.inb   = (cpos >= (COL_W+1)'(HALF)) && (cpos - (COL_W+1)'(HALF) < (COL_W+1)'(w))
             && (rpos >= (HGT_W+1)'(HALF)) && (rpos - (HGT_W+1)'(HALF) < {1'b0, h});
  end

  assign div_start = (state == ST_DRAIN) && !w_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (advance) begin
            cur_col  <= in_column;
            cur_pix  <= in_done ? '0 : pixel_in;
            cur_emit <= pos >= lag;
            if (in_column_inc >= (COL_W+1)'(w)) begin
              in_column <= '0;
              in_row    <= in_row + 1'b1;
            end else begin
              in_column <= in_column_inc[COL_W-1:0];
            end
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (cur_emit) begin
            tap_oc  <= out_column;
            tap_or  <= out_row;
            res_eol <= eol;
            res_eof <= eof;
            tj      <= '0;
            ti      <= '0;
            if (eof) begin
              in_column  <= '0;
              in_row     <= '0;
              out_column <= '0;
              out_row    <= '0;
            end else if (eol) begin
              out_column <= '0;
              out_row    <= out_row_inc[HGT_W-1:0];
            end else begin
              out_column <= out_column_inc[COL_W-1:0];
            end
            state <= ST_TAPS;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_TAPS: begin
          if (ti == TAP_W'(SPAN - 1)) begin
            ti <= '0;
            if (tj == TAP_W'(SPAN - 1)) state <= ST_DRAIN;
            else tj <= tj + 1'b1;
          end else begin
            ti <= ti + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!w_busy) state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            pixel_out    <= quot;
            end_of_line  <= res_eol;
            end_of_frame <= res_eof;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bf2d_weight u_weight (
    .clk           (clk),
    .rst           (rst),
    .clear         (state == ST_SHIFT),
    .tap           (tap),
    .range_coeff   (range_coeff),
    .spatial_coeff (spatial_coeff),
    .busy          (w_busy),
    .wsum_px       (wsum_px),
    .wsum          (wsum)
  );

  bf2d_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_in (wsum_px),
    .den_in (wsum),
    .done   (div_done),
    .quot   (quot)
  );

endmodule
`default_nettype wire
